### design/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; used by every module of the block.
`default_nettype none

package spq_pkg;

    // Default number of cells in the chain.
    localparam int QueueDepthDefault = 16;

    localparam int TagW  = 16;
    localparam int PrioW = 16;

    // Operation codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CONTAINS = 2'd2,
        KIND_NOP      = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    // One queue entry.
    typedef struct packed {
        logic [TagW-1:0]         tag;
        logic signed [PrioW-1:0] prio;
    } entry_t;

    // Control broadcast from the top level to all cells.
    typedef struct packed {
        cell_op_t op;
        entry_t   ins;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### design/spq_cell.sv
// One cell of the sorted chain: holds a single entry and moves it to or from
// its neighbors on insert and remove. Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic                  clk,
    input  wire spq_pkg::cell_ctrl_t   ctrl,
    input  wire logic                  own_valid,
    input  wire logic                  left_keep,
    input  wire spq_pkg::entry_t       left_entry,
    input  wire spq_pkg::entry_t       right_entry,
    output logic                       keep,
    output spq_pkg::entry_t            entry,
    output spq_pkg::entry_t            entry_next
);

    spq_pkg::entry_t entry_reg;

    // A cell keeps its entry on insert when it ranks at or above the new one,
    // so equal priorities stay ahead of later arrivals.
    assign keep  = own_valid && ($signed(entry_reg.prio) >= $signed(ctrl.ins.prio));
    assign entry = entry_reg;

    // Next entry: hold, take the new word, or take a neighbor's entry.
    always_comb
    begin
        unique case (ctrl.op)
            spq_pkg::CELL_INSERT:
            begin
                if (keep)
                begin
                    entry_next = entry_reg;
                end
                else if (left_keep)
                begin
                    entry_next = ctrl.ins;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
            spq_pkg::CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Payload storage; validity comes from the count in the top level.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### design/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell instances,
// the entry count and the registered result word. Depends on spq_pkg, spq_cell.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready kind item_tag  | into block
//          | item_priority                    |
//  out     | out_valid out_ready status ...   | out of block
//
// All cells compare the priority of an accepted word in parallel and shift
// together, so the result register loads at the accepting edge. A word is
// accepted whenever the result register is free or being emptied in the
// same cycle, giving one word per cycle while out_ready stays high; a result
// word held by the receiver stalls the input.
// Reset empties the queue at once; entry payloads are not cleared.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault,
    localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                kind,
    input  wire logic [spq_pkg::TagW-1:0]  item_tag,
    input  wire logic signed [spq_pkg::PrioW-1:0] item_priority,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status,
    output logic [spq_pkg::TagW-1:0]       removed_tag,
    output logic signed [spq_pkg::PrioW-1:0] removed_priority,
    output logic                           found,
    output logic                           head_valid,
    output logic [spq_pkg::TagW-1:0]       head_tag,
    output logic signed [spq_pkg::PrioW-1:0] head_priority,
    output logic [CntW-1:0]                entry_count
);

    spq_pkg::kind_t     kind_in;
    spq_pkg::cell_ctrl_t ctrl;
    logic               accept;
    logic               is_full;
    logic               is_empty;

    logic [CntW-1:0]    count_reg;
    logic [CntW-1:0]    count_next;

    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_keep;
    logic [QUEUE_DEPTH-1:0] cell_match;
    spq_pkg::entry_t    cell_entry      [QUEUE_DEPTH];
    spq_pkg::entry_t    cell_entry_next [QUEUE_DEPTH];

    logic               out_valid_reg;
    spq_pkg::status_t   status_reg;
    spq_pkg::status_t   status_next;
    spq_pkg::entry_t    removed_reg;
    spq_pkg::entry_t    removed_next;
    logic               found_reg;
    logic               found_next;
    spq_pkg::entry_t    head_reg;
    spq_pkg::entry_t    head_next;
    logic [CntW-1:0]    count_out_reg;

    assign kind_in  = spq_pkg::kind_t'(kind);
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CntW'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Broadcast operation for the chain.
    always_comb
    begin
        ctrl.ins.tag  = item_tag;
        ctrl.ins.prio = item_priority;
        ctrl.op       = spq_pkg::CELL_HOLD;
        if (accept && (kind_in == spq_pkg::KIND_INSERT) && !is_full)
        begin
            ctrl.op = spq_pkg::CELL_INSERT;
        end
        else if (accept && (kind_in == spq_pkg::KIND_REMOVE) && !is_empty)
        begin
            ctrl.op = spq_pkg::CELL_SHIFT;
        end
    end

    // The chain of cells; a cell holds a live entry when it lies below the count.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t left_e;
        spq_pkg::entry_t right_e;
        logic            left_k;

        assign cell_valid[i] = (count_reg > CntW'(i));
        assign cell_match[i] = cell_valid[i] && (cell_entry[i].tag == item_tag);

        if (i == 0)
        begin : g_first
            assign left_k = 1'b1;
            assign left_e = ctrl.ins;
        end
        else
        begin : g_mid
            assign left_k = cell_keep[i-1];
            assign left_e = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .own_valid  (cell_valid[i]),
            .left_keep  (left_k),
            .left_entry (left_e),
            .right_entry(right_e),
            .keep       (cell_keep[i]),
            .entry      (cell_entry[i]),
            .entry_next (cell_entry_next[i])
        );
    end

    // Count and result word for the accepted operation.
    always_comb
    begin
        count_next   = count_reg;
        status_next  = spq_pkg::ST_OK;
        removed_next = '0;
        found_next   = 1'b0;
        unique case (kind_in)
            spq_pkg::KIND_INSERT:
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CntW'(1);
                end
            end
            spq_pkg::KIND_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next   = count_reg - CntW'(1);
                    removed_next = cell_entry[0];
                end
            end
            spq_pkg::KIND_CONTAINS:
            begin
                found_next = |cell_match;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        head_next = (count_next != '0) ? cell_entry_next[0] : '0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            found_reg     <= found_next;
            head_reg      <= head_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign removed_tag      = removed_reg.tag;
    assign removed_priority = removed_reg.prio;
    assign found            = found_reg;
    assign head_valid       = (count_out_reg != '0);
    assign head_tag         = head_reg.tag;
    assign head_priority    = head_reg.prio;
    assign entry_count      = count_out_reg;

endmodule

`default_nettype wire

### design/spq_checker.sv
// Port-level checks for sorted_priority_queue, bound to the top level.
// Depends on spq_pkg.
`default_nettype none

module spq_checker #(
    parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault,
    localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [1:0]                status,
    input wire logic [spq_pkg::TagW-1:0]  removed_tag,
    input wire logic signed [spq_pkg::PrioW-1:0] removed_priority,
    input wire logic                      head_valid,
    input wire logic [spq_pkg::TagW-1:0]  head_tag,
    input wire logic [CntW-1:0]           entry_count
);

    // A stalled result word holds its values.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(head_tag)
            && $stable(entry_count))
        else $error("result word changed while stalled");

    // Every accepted word produces a result in the next cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    // Head visibility follows the count.
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (entry_count != '0)))
        else $error("head_valid disagrees with entry_count");

    // Remove on empty leaves an empty queue and no popped entry.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spq_pkg::ST_EMPTY) |->
            (entry_count == '0) && (removed_tag == '0) && (removed_priority == '0))
        else $error("bad result for remove on empty queue");

    // A dropped insert is reported only with a full queue.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spq_pkg::ST_FULL) |-> (entry_count == CntW'(QUEUE_DEPTH)))
        else $error("full status with queue not full");

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

`default_nettype wire
